// File: rtl/core/lz77_huffman_stream_decoder_unit_defines.svh
// assertion macros used by the decoder controller
`ifndef LZ77_HUFFMAN_STREAM_DECODER_UNIT_DEFINES_SVH
`define LZ77_HUFFMAN_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LZHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzhd assertion failed");

// next-cycle implication, checked outside reset
`define LZHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzhd assertion failed");

`endif

// File: rtl/core/lzhd_pkg.sv
// shared types, constants and tables of the stream decoder
`timescale 1ns / 1ps
`default_nettype none
package lzhd_pkg;

    localparam int unsigned WINDOW_SIZE_DEF      = 32768;
    localparam int unsigned LIT_SYMBOL_BITS_DEF  = 9;
    localparam int unsigned DIST_SYMBOL_BITS_DEF = 5;
    localparam int unsigned LIT_TREE_NODES_DEF   = 1024;
    localparam int unsigned DIST_TREE_NODES_DEF  = 64;
    localparam int unsigned TREE_STACK_DEPTH_DEF = 32;

    localparam int unsigned NODE_VAL_W = 16;
    localparam int unsigned NODE_W     = NODE_VAL_W + 1;
    localparam int unsigned FIELD_W    = 13;
    localparam int unsigned FLEN_W     = 4;
    localparam int unsigned LEN_W      = 9;
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned LANES_W    = 64;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned BYTE_W     = 8;

    localparam int unsigned SYM_EOB       = 256;
    localparam int unsigned SYM_LEN_FIRST = 257;
    localparam int unsigned SYM_LEN_LAST  = 285;
    localparam int unsigned DIST_TBL_SIZE = 32;

    // length codes 257..285, tail entries unused
    localparam logic [LEN_W-1:0] LEN_BASE [32] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258, 9'd0, 9'd0, 9'd0};
    localparam logic [FLEN_W-1:0] LEN_EXTRA [32] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0};
    // distance codes 30 and 31 read as zero distance, which is an error
    localparam logic [DIST_W-1:0] DIST_BASE [32] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
        16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
        16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
        16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577, 16'd0, 16'd0};
    localparam logic [FLEN_W-1:0] DIST_EXTRA [32] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13, 4'd0, 4'd0};

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTES = 2'd0,
        KIND_EOB   = 2'd1,
        KIND_ERR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OUT_LIT,
        OUT_COPY,
        OUT_NONE
    } t_out_sel;

    typedef enum logic [3:0] {
        PH_LIT_TREE_NODE,
        PH_LIT_TREE_SYM,
        PH_DIST_TREE_NODE,
        PH_DIST_TREE_SYM,
        PH_LIT,
        PH_LEN_EXTRA,
        PH_DIST,
        PH_DIST_EXTRA,
        PH_HALT
    } t_phase;

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_LEAF,
        ST_POP,
        ST_LINK,
        ST_WALK_PTR,
        ST_WALK_CHK,
        ST_SYM,
        ST_LEN_ADD,
        ST_DIST_ADD,
        ST_COPY_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_COPY_OUT,
        ST_FAIL
    } t_state;

    typedef struct packed {
        logic     tree_sel;
        logic     node_leaf_push;
        logic     node_int_push;
        logic     field_take;
        logic     leaf_write;
        logic     stack_pop;
        logic     link_write;
        logic     begin_tree;
        logic     cursor_clr;
        logic     walk_rd_cur;
        logic     walk_step_ptr;
        logic     walk_step_inc;
        logic     sym_latch;
        logic     len_set_sym;
        logic     len_add;
        logic     dist_set_sym;
        logic     dist_add;
        logic     lit_put;
        logic     copy_init;
        logic     copy_rd;
        logic     copy_wr;
        logic     out_load;
        t_out_sel out_sel;
        t_kind    out_kind;
    } t_cmd;

    typedef struct packed {
        logic bit_in;
        logic node_full;
        logic alloc_zero;
        logic stack_full;
        logic stack_empty;
        logic field_last;
        logic node_leaf;
        logic sym_byte;
        logic sym_eob;
        logic len_extra_nz;
        logic dist_extra_nz;
        logic dist_bad;
        logic len_zero;
        logic rem_one;
        logic cnt_seven;
        logic rem_zero;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/core/lzhd_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lzhd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/core/lzhd_datapath.sv
// decoder datapath: tree, stack and window memories, field and copy registers, output word
`timescale 1ns / 1ps
`default_nettype none
module lzhd_datapath #(
    parameter int unsigned WINDOW_SIZE      = lzhd_pkg::WINDOW_SIZE_DEF,
    parameter int unsigned LIT_SYMBOL_BITS  = lzhd_pkg::LIT_SYMBOL_BITS_DEF,
    parameter int unsigned DIST_SYMBOL_BITS = lzhd_pkg::DIST_SYMBOL_BITS_DEF,
    parameter int unsigned LIT_TREE_NODES   = lzhd_pkg::LIT_TREE_NODES_DEF,
    parameter int unsigned DIST_TREE_NODES  = lzhd_pkg::DIST_TREE_NODES_DEF,
    parameter int unsigned TREE_STACK_DEPTH = lzhd_pkg::TREE_STACK_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire logic                          i_stream_bit,
    input  wire logic                          i_stall,
    input  wire lzhd_pkg::t_cmd                i_cmd,
    output lzhd_pkg::t_sts                     o_sts,
    output logic                               o_valid,
    output logic [lzhd_pkg::LANES_W-1:0]       o_byte_lanes,
    output logic [lzhd_pkg::COUNT_W-1:0]       o_byte_count,
    output logic [lzhd_pkg::KIND_W-1:0]        o_kind,
    output logic                               o_last_of_run
);
    import lzhd_pkg::*;

    localparam int unsigned LAW  = $clog2(LIT_TREE_NODES);
    localparam int unsigned DAW  = $clog2(DIST_TREE_NODES);
    localparam int unsigned ALW  = LAW + 1;
    localparam int unsigned SAW  = $clog2(TREE_STACK_DEPTH);
    localparam int unsigned STW  = $clog2(TREE_STACK_DEPTH + 1);
    localparam int unsigned WAW  = $clog2(WINDOW_SIZE);
    localparam int unsigned SATW = $clog2(WINDOW_SIZE + 1);
    localparam int unsigned PW   = ((WAW > DIST_W) ? WAW : DIST_W) + 2;

    logic                 r_msb;
    logic [FIELD_W-1:0]   r_field, n_field;
    logic [FLEN_W-1:0]    r_left, n_left;
    logic [FLEN_W-1:0]    r_flen, n_flen;
    logic [LAW-1:0]       r_cursor, n_cursor;
    logic [ALW-1:0]       r_alloc, n_alloc;
    logic [STW-1:0]       r_top, n_top;
    logic [NODE_VAL_W-1:0] r_sym, n_sym;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [DIST_W-1:0]    r_dist, n_dist;
    logic [WAW-1:0]       r_wp, n_wp;
    logic [SATW-1:0]      r_sat, n_sat;
    logic [LEN_W-1:0]     r_rem, n_rem;
    logic [COUNT_W-1:0]   r_cnt, n_cnt;
    logic [LANES_W-1:0]   r_lanes, n_lanes;
    logic                 r_ovalid, n_ovalid;
    logic [LANES_W-1:0]   r_olanes, n_olanes;
    logic [COUNT_W-1:0]   r_ocount, n_ocount;
    t_kind                r_okind, n_okind;
    logic                 r_olast, n_olast;

    logic                 node_we, node_re;
    logic [LAW-1:0]       node_waddr, node_raddr;
    logic [NODE_W-1:0]    node_wdata, node_rdata, lit_rdata, dist_rdata;
    logic                 stack_we, stack_re;
    logic [STW-1:0]       top_dec;
    logic [LAW-1:0]       stack_rdata;
    logic                 win_we, win_re;
    logic [WAW-1:0]       win_raddr;
    logic [BYTE_W-1:0]    win_wdata, win_rdata;

    logic [FLEN_W-1:0]    pos;
    logic                 is_len, dsym_ok, out_free;
    logic [4:0]           len_idx, dist_idx;
    logic [PW-1:0]        src_diff;
    logic [WAW-1:0]       wp_inc;
    logic [SATW-1:0]      sat_inc;

    lzhd_ram #(.WIDTH(NODE_W), .DEPTH(LIT_TREE_NODES)) u_lit_nodes (
        .i_clk(i_clk), .i_we(node_we && !i_cmd.tree_sel), .i_waddr(node_waddr),
        .i_wdata(node_wdata), .i_re(node_re && !i_cmd.tree_sel), .i_raddr(node_raddr),
        .o_rdata(lit_rdata)
    );

    lzhd_ram #(.WIDTH(NODE_W), .DEPTH(DIST_TREE_NODES)) u_dist_nodes (
        .i_clk(i_clk), .i_we(node_we && i_cmd.tree_sel), .i_waddr(node_waddr[DAW-1:0]),
        .i_wdata(node_wdata), .i_re(node_re && i_cmd.tree_sel),
        .i_raddr(node_raddr[DAW-1:0]), .o_rdata(dist_rdata)
    );

    lzhd_ram #(.WIDTH(LAW), .DEPTH(TREE_STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr(r_top[SAW-1:0]),
        .i_wdata(r_alloc[LAW-1:0]), .i_re(stack_re), .i_raddr(top_dec[SAW-1:0]),
        .o_rdata(stack_rdata)
    );

    lzhd_ram #(.WIDTH(BYTE_W), .DEPTH(WINDOW_SIZE)) u_window (
        .i_clk(i_clk), .i_we(win_we), .i_waddr(r_wp), .i_wdata(win_wdata),
        .i_re(win_re), .i_raddr(win_raddr), .o_rdata(win_rdata)
    );

    assign node_rdata = i_cmd.tree_sel ? dist_rdata : lit_rdata;
    assign top_dec    = STW'(r_top - 1'b1);
    assign pos        = FLEN_W'(r_flen - r_left);
    assign is_len     = (r_sym >= NODE_VAL_W'(SYM_LEN_FIRST))
                        && (r_sym <= NODE_VAL_W'(SYM_LEN_LAST));
    assign len_idx    = 5'(r_sym - NODE_VAL_W'(SYM_LEN_FIRST));
    assign dsym_ok    = r_sym < NODE_VAL_W'(DIST_TBL_SIZE);
    assign dist_idx   = r_sym[4:0];
    assign out_free   = !r_ovalid || !i_stall;
    assign wp_inc     = (r_wp == WAW'(WINDOW_SIZE - 1)) ? '0 : WAW'(r_wp + 1'b1);
    assign sat_inc    = (r_sat < SATW'(WINDOW_SIZE)) ? SATW'(r_sat + 1'b1) : r_sat;

    // copy source trails the write pointer by the distance, modulo the window
    always_comb begin
        src_diff = PW'(r_wp) - PW'(r_dist);
        if (PW'(r_wp) < PW'(r_dist)) begin
            src_diff = PW'(src_diff + PW'(WINDOW_SIZE));
        end
        win_raddr = src_diff[WAW-1:0];
    end

    always_comb begin
        n_field  = r_field;
        n_left   = r_left;
        n_flen   = r_flen;
        n_cursor = r_cursor;
        n_alloc  = r_alloc;
        n_top    = r_top;
        n_sym    = r_sym;
        n_len    = r_len;
        n_dist   = r_dist;
        n_wp     = r_wp;
        n_sat    = r_sat;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_lanes  = r_lanes;
        n_ovalid = r_ovalid;
        n_olanes = r_olanes;
        n_ocount = r_ocount;
        n_okind  = r_okind;
        n_olast  = r_olast;

        node_we    = 1'b0;
        node_waddr = r_cursor;
        node_wdata = '0;
        node_re    = 1'b0;
        node_raddr = r_cursor;
        stack_we   = 1'b0;
        stack_re   = 1'b0;
        win_we     = 1'b0;
        win_re     = 1'b0;
        win_wdata  = win_rdata;

        if (i_cmd.node_leaf_push) begin
            node_we    = 1'b1;
            node_waddr = r_alloc[LAW-1:0];
            node_wdata = {1'b1, NODE_VAL_W'(0)};
            n_cursor   = r_alloc[LAW-1:0];
            n_alloc    = ALW'(r_alloc + 1'b1);
            n_field    = '0;
            n_flen     = i_cmd.tree_sel ? FLEN_W'(DIST_SYMBOL_BITS) : FLEN_W'(LIT_SYMBOL_BITS);
            n_left     = n_flen;
        end
        if (i_cmd.node_int_push) begin
            node_we    = 1'b1;
            node_waddr = r_alloc[LAW-1:0];
            node_wdata = '0;
            stack_we   = 1'b1;
            n_top      = STW'(r_top + 1'b1);
            n_alloc    = ALW'(r_alloc + 1'b1);
        end
        if (i_cmd.field_take) begin
            if (r_msb) begin
                n_field = {r_field[FIELD_W-2:0], i_stream_bit};
            end else begin
                n_field = r_field | (FIELD_W'(i_stream_bit) << pos);
            end
            n_left = FLEN_W'(r_left - 1'b1);
        end
        if (i_cmd.leaf_write) begin
            node_we    = 1'b1;
            node_waddr = r_cursor;
            node_wdata = {1'b1, NODE_VAL_W'(r_field)};
        end
        if (i_cmd.stack_pop) begin
            stack_re = 1'b1;
            n_top    = top_dec;
        end
        if (i_cmd.link_write) begin
            node_we    = 1'b1;
            node_waddr = stack_rdata;
            node_wdata = {1'b0, NODE_VAL_W'(r_alloc)};
        end
        if (i_cmd.walk_rd_cur) begin
            node_re    = 1'b1;
            node_raddr = r_cursor;
        end
        if (i_cmd.walk_step_ptr) begin
            node_re    = 1'b1;
            node_raddr = node_rdata[LAW-1:0];
            n_cursor   = node_raddr;
        end
        if (i_cmd.walk_step_inc) begin
            node_re    = 1'b1;
            node_raddr = LAW'(r_cursor + 1'b1);
            n_cursor   = node_raddr;
        end
        if (i_cmd.sym_latch) begin
            n_sym = node_rdata[NODE_VAL_W-1:0];
        end
        if (i_cmd.begin_tree) begin
            n_alloc  = '0;
            n_top    = '0;
            n_cursor = '0;
        end
        if (i_cmd.cursor_clr) begin
            n_cursor = '0;
        end
        if (i_cmd.len_set_sym) begin
            n_len   = is_len ? LEN_BASE[len_idx] : '0;
            n_field = '0;
            n_flen  = is_len ? LEN_EXTRA[len_idx] : '0;
            n_left  = n_flen;
        end
        if (i_cmd.len_add) begin
            n_len = LEN_W'(r_len + r_field[LEN_W-1:0]);
        end
        if (i_cmd.dist_set_sym) begin
            n_dist  = dsym_ok ? DIST_BASE[dist_idx] : '0;
            n_field = '0;
            n_flen  = dsym_ok ? DIST_EXTRA[dist_idx] : '0;
            n_left  = n_flen;
        end
        if (i_cmd.dist_add) begin
            n_dist = DIST_W'(r_dist + DIST_W'(r_field));
        end
        if (i_cmd.lit_put) begin
            win_we    = 1'b1;
            win_wdata = r_sym[BYTE_W-1:0];
            n_wp      = wp_inc;
            n_sat     = sat_inc;
        end
        if (i_cmd.copy_init) begin
            n_rem   = r_len;
            n_cnt   = '0;
            n_lanes = '0;
        end
        if (i_cmd.copy_rd) begin
            win_re = 1'b1;
        end
        if (i_cmd.copy_wr) begin
            win_we    = 1'b1;
            win_wdata = win_rdata;
            n_wp      = wp_inc;
            n_sat     = sat_inc;
            n_lanes[r_cnt[2:0]*BYTE_W +: BYTE_W] = win_rdata;
            n_cnt     = COUNT_W'(r_cnt + 1'b1);
            n_rem     = LEN_W'(r_rem - 1'b1);
        end

        // output word register, refilled as the old word leaves
        if (i_cmd.out_load) begin
            n_ovalid = 1'b1;
            n_okind  = i_cmd.out_kind;
            n_olast  = 1'b1;
            case (i_cmd.out_sel)
                OUT_LIT: begin
                    n_olanes = LANES_W'(r_sym[BYTE_W-1:0]);
                    n_ocount = COUNT_W'(1);
                end
                OUT_COPY: begin
                    n_olanes = r_lanes;
                    n_ocount = r_cnt;
                    n_olast  = (r_rem == '0);
                    n_lanes  = '0;
                    n_cnt    = '0;
                end
                default: begin
                    n_olanes = '0;
                    n_ocount = '0;
                end
            endcase
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb    <= 1'b0;
            r_left   <= '0;
            r_flen   <= '0;
            r_field  <= '0;
            r_cursor <= '0;
            r_alloc  <= '0;
            r_top    <= '0;
            r_len    <= '0;
            r_dist   <= '0;
            r_wp     <= '0;
            r_sat    <= '0;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_msb <= i_cfg_wdata;
            end
            r_left   <= n_left;
            r_flen   <= n_flen;
            r_field  <= n_field;
            r_cursor <= n_cursor;
            r_alloc  <= n_alloc;
            r_top    <= n_top;
            r_len    <= n_len;
            r_dist   <= n_dist;
            r_wp     <= n_wp;
            r_sat    <= n_sat;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym    <= n_sym;
        r_lanes  <= n_lanes;
        r_olanes <= n_olanes;
        r_ocount <= n_ocount;
        r_okind  <= n_okind;
        r_olast  <= n_olast;
    end

    always_comb begin
        o_sts               = '0;
        o_sts.bit_in        = i_stream_bit;
        o_sts.node_full     = i_cmd.tree_sel ? (r_alloc >= ALW'(DIST_TREE_NODES))
                                             : (r_alloc >= ALW'(LIT_TREE_NODES));
        o_sts.alloc_zero    = (r_alloc == '0);
        o_sts.stack_full    = (r_top >= STW'(TREE_STACK_DEPTH));
        o_sts.stack_empty   = (r_top == '0);
        o_sts.field_last    = (r_left == FLEN_W'(1));
        o_sts.node_leaf     = node_rdata[NODE_W-1];
        o_sts.sym_byte      = (r_sym < NODE_VAL_W'(SYM_EOB));
        o_sts.sym_eob       = (r_sym == NODE_VAL_W'(SYM_EOB));
        o_sts.len_extra_nz  = is_len && (LEN_EXTRA[len_idx] != '0);
        o_sts.dist_extra_nz = dsym_ok && (DIST_EXTRA[dist_idx] != '0);
        o_sts.dist_bad      = (r_dist == '0) || (PW'(r_dist) > PW'(r_sat));
        o_sts.len_zero      = (r_len == '0);
        o_sts.rem_one       = (r_rem == LEN_W'(1));
        o_sts.cnt_seven     = (r_cnt == COUNT_W'(7));
        o_sts.rem_zero      = (r_rem == '0);
        o_sts.out_free      = out_free;
    end

    assign o_valid       = r_ovalid;
    assign o_byte_lanes  = r_olanes;
    assign o_byte_count  = r_ocount;
    assign o_kind        = r_okind;
    assign o_last_of_run = r_olast;
endmodule
`default_nettype wire

// File: rtl/core/lzhd_ctrl.sv
// decoder controller: stream phase and per-bit step sequencing
`timescale 1ns / 1ps
`default_nettype none
module lzhd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire lzhd_pkg::t_sts i_sts,
    output lzhd_pkg::t_cmd      o_cmd
);
    import lzhd_pkg::*;
    `include "lz77_huffman_stream_decoder_unit_defines.svh"

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   dist_side;

    assign dist_side = (r_phase == PH_DIST_TREE_NODE) || (r_phase == PH_DIST_TREE_SYM)
                       || (r_phase == PH_DIST) || (r_phase == PH_DIST_EXTRA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
            r_phase <= PH_LIT_TREE_NODE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        o_cmd          = '0;
        o_cmd.tree_sel = dist_side;
        o_cmd.out_sel  = OUT_NONE;
        o_cmd.out_kind = KIND_BYTES;
        o_stall        = (r_state != ST_WAIT);

        case (r_state)
            ST_WAIT: begin
                if (i_valid) begin
                    case (r_phase)
                        PH_LIT_TREE_NODE, PH_DIST_TREE_NODE: begin
                            if (i_sts.node_full) begin
                                n_state = ST_FAIL;
                            end else if (i_sts.bit_in) begin
                                // a leaf at the root is a malformed tree
                                if (i_sts.alloc_zero) begin
                                    n_state = ST_FAIL;
                                end else begin
                                    o_cmd.node_leaf_push = 1'b1;
                                    n_phase = dist_side ? PH_DIST_TREE_SYM : PH_LIT_TREE_SYM;
                                end
                            end else if (i_sts.stack_full) begin
                                n_state = ST_FAIL;
                            end else begin
                                o_cmd.node_int_push = 1'b1;
                            end
                        end
                        PH_LIT_TREE_SYM, PH_DIST_TREE_SYM: begin
                            o_cmd.field_take = 1'b1;
                            if (i_sts.field_last) begin
                                n_state = ST_LEAF;
                            end
                        end
                        PH_LIT, PH_DIST: begin
                            if (i_sts.bit_in) begin
                                o_cmd.walk_rd_cur = 1'b1;
                                n_state = ST_WALK_PTR;
                            end else begin
                                o_cmd.walk_step_inc = 1'b1;
                                n_state = ST_WALK_CHK;
                            end
                        end
                        PH_LEN_EXTRA: begin
                            o_cmd.field_take = 1'b1;
                            if (i_sts.field_last) begin
                                n_state = ST_LEN_ADD;
                            end
                        end
                        PH_DIST_EXTRA: begin
                            o_cmd.field_take = 1'b1;
                            if (i_sts.field_last) begin
                                n_state = ST_DIST_ADD;
                            end
                        end
                        default: begin
                            // halted: words are taken and dropped
                        end
                    endcase
                end
            end
            ST_LEAF: begin
                o_cmd.leaf_write = 1'b1;
                if (i_sts.stack_empty) begin
                    n_state = ST_WAIT;
                    if (dist_side) begin
                        n_phase = PH_LIT;
                        o_cmd.cursor_clr = 1'b1;
                    end else begin
                        n_phase = PH_DIST_TREE_NODE;
                        o_cmd.begin_tree = 1'b1;
                    end
                end else begin
                    o_cmd.stack_pop = 1'b1;
                    n_phase = dist_side ? PH_DIST_TREE_NODE : PH_LIT_TREE_NODE;
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_LINK;
            end
            ST_LINK: begin
                o_cmd.link_write = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WALK_PTR: begin
                o_cmd.walk_step_ptr = 1'b1;
                n_state = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (i_sts.node_leaf) begin
                    o_cmd.sym_latch  = 1'b1;
                    o_cmd.cursor_clr = 1'b1;
                    n_state = ST_SYM;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_SYM: begin
                if (r_phase == PH_DIST) begin
                    o_cmd.dist_set_sym = 1'b1;
                    if (i_sts.dist_extra_nz) begin
                        n_phase = PH_DIST_EXTRA;
                        n_state = ST_WAIT;
                    end else begin
                        n_state = ST_COPY_CHK;
                    end
                end else if (i_sts.sym_byte) begin
                    if (i_sts.out_free) begin
                        o_cmd.lit_put  = 1'b1;
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_LIT;
                        n_state = ST_WAIT;
                    end
                end else if (i_sts.sym_eob) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_kind   = KIND_EOB;
                        o_cmd.begin_tree = 1'b1;
                        n_phase = PH_LIT_TREE_NODE;
                        n_state = ST_WAIT;
                    end
                end else begin
                    o_cmd.len_set_sym = 1'b1;
                    n_phase = i_sts.len_extra_nz ? PH_LEN_EXTRA : PH_DIST;
                    n_state = ST_WAIT;
                end
            end
            ST_LEN_ADD: begin
                o_cmd.len_add = 1'b1;
                n_phase = PH_DIST;
                n_state = ST_WAIT;
            end
            ST_DIST_ADD: begin
                o_cmd.dist_add = 1'b1;
                n_state = ST_COPY_CHK;
            end
            ST_COPY_CHK: begin
                if (i_sts.dist_bad) begin
                    n_state = ST_FAIL;
                end else begin
                    o_cmd.copy_init = 1'b1;
                    n_phase = PH_LIT;
                    n_state = i_sts.len_zero ? ST_WAIT : ST_COPY_RD;
                end
            end
            ST_COPY_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                n_state = (i_sts.rem_one || i_sts.cnt_seven) ? ST_COPY_OUT : ST_COPY_RD;
            end
            ST_COPY_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_COPY;
                    n_state = i_sts.rem_zero ? ST_WAIT : ST_COPY_RD;
                end
            end
            ST_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = KIND_ERR;
                    n_phase = PH_HALT;
                    n_state = ST_WAIT;
                end
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase
    end

    `LZHD_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free)
    `LZHD_ASSERT_IMP(a_halt_is_quiet, i_clk, i_rst_n, r_phase == PH_HALT, !o_cmd.out_load && r_state == ST_WAIT)
    `LZHD_ASSERT_NXT(a_fail_halts, i_clk, i_rst_n, r_state == ST_FAIL && i_sts.out_free, r_phase == PH_HALT)
endmodule
`default_nettype wire

// File: rtl/core/lz77_huffman_stream_decoder_unit.sv
// top level of the bit-serial lz77 and code-tree stream decoder
// tree and extra bits: one word per cycle while o_stall is low; a leaf that closes a subtree adds
// the pop and link states; a right code bit adds a pointer read to the walk; a symbol hit adds the
// symbol state; a copy reads then writes each byte through the single window read port and
// loads each output word; all results come out through one output register, so a stalled output
// only holds back work that produces results; reset is synchronous, active low, and clears control state
`timescale 1ns / 1ps
`default_nettype none
module lz77_huffman_stream_decoder_unit #(
    parameter int unsigned WINDOW_SIZE      = lzhd_pkg::WINDOW_SIZE_DEF,
    parameter int unsigned LIT_SYMBOL_BITS  = lzhd_pkg::LIT_SYMBOL_BITS_DEF,
    parameter int unsigned DIST_SYMBOL_BITS = lzhd_pkg::DIST_SYMBOL_BITS_DEF,
    parameter int unsigned LIT_TREE_NODES   = lzhd_pkg::LIT_TREE_NODES_DEF,
    parameter int unsigned DIST_TREE_NODES  = lzhd_pkg::DIST_TREE_NODES_DEF,
    parameter int unsigned TREE_STACK_DEPTH = lzhd_pkg::TREE_STACK_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: first_bit_is_msb
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    // compressed stream, one bit per word
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_stream_bit,
    // decoded words
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [lzhd_pkg::LANES_W-1:0]       o_byte_lanes,
    output logic [lzhd_pkg::COUNT_W-1:0]       o_byte_count,
    output logic [lzhd_pkg::KIND_W-1:0]        o_kind,
    output logic                               o_last_of_run
);
    import lzhd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller owns the stream phase and steps one word through the datapath
    lzhd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath holds the trees, build stack, history window and output register
    lzhd_datapath #(
        .WINDOW_SIZE      (WINDOW_SIZE),
        .LIT_SYMBOL_BITS  (LIT_SYMBOL_BITS),
        .DIST_SYMBOL_BITS (DIST_SYMBOL_BITS),
        .LIT_TREE_NODES   (LIT_TREE_NODES),
        .DIST_TREE_NODES  (DIST_TREE_NODES),
        .TREE_STACK_DEPTH (TREE_STACK_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_stream_bit  (i_stream_bit),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_byte_lanes  (o_byte_lanes),
        .o_byte_count  (o_byte_count),
        .o_kind        (o_kind),
        .o_last_of_run (o_last_of_run)
    );
endmodule
`default_nettype wire
